@@ hw/rtl/ima_adpcm_frame_decoder_core_macros.svh @@
// assertion helpers for the adpcm decoder
`ifndef IMA_ADPCM_FRAME_DECODER_CORE_MACROS_SVH
`define IMA_ADPCM_FRAME_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IMADEC_ASSERT_CR(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IMADEC_ASSERT(label, prop, msg) \
   `IMADEC_ASSERT_CR(label, clock, reset, prop, msg)
`else
`define IMADEC_ASSERT_CR(label, clk, rst, prop, msg)
`define IMADEC_ASSERT(label, prop, msg)
`endif
`endif

@@ hw/rtl/imadec_pkg.sv @@
package imadec_pkg;

   localparam logic [6:0] MAX_INDEX = 7'd88;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_INDEX,
      STATUS_BAD_LENGTH
   } status_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               end_of_frame;
      status_type         status;
   } result_type;

   localparam logic signed [4:0] INDEX_ADJUST [8] = '{
      -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
   };

   localparam logic [14:0] STEP_TABLE [89] = '{
      15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
      15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
      15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
      15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
      15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
      15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
      15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
      15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
      15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
      15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
      15'd27086, 15'd29794, 15'd32767
   };

endpackage

@@ hw/rtl/ima_adpcm_frame_decoder_core.sv @@
// IMA ADPCM mono packet decoder, one packet byte per request.
// Input channel req_*: req_data_byte with req_first_byte marking the first byte
// of a packet and req_final_byte its last. Result channel rsp_*: one decoded
// sample per result, with rsp_end_of_frame on the last result of the packet
// and rsp_status (ok, bad step index, wrong length).
// Bytes 0/1 carry the predictor, byte 2 the step index (emits sample 0),
// byte 3 is skipped, later bytes give up to two samples each, low nibble first.
// A result is written into the result queue when its request is taken.
// Throughput: one byte per cycle while req_stall is low and bytes give at most
// one result; a byte giving two samples puts both on the single result port in
// turn, so a decoding run fills the queue and req_stall holds bytes back. Both
// nibble decodes of a byte run in the same cycle from the predictor and step
// registers. A four-entry result queue sits between the sides; req_stall rises
// when it cannot take two more results, so a stalled receiver backs up into
// the request side without losing results.
// Reset (synchronous) empties the queue and zeroes the decoder state.
module ima_adpcm_frame_decoder_core #(
   parameter int PACKET_LEN        = 84,
   parameter int SAMPLES_PER_FRAME = 160
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_first_byte,
   input  logic               req_final_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_end_of_frame,
   output logic [1:0]         rsp_status
);
   import imadec_pkg::*;

   localparam logic [7:0] PacketLenW = 8'(PACKET_LEN);
   localparam logic [6:0] LastIdx    = 7'(PACKET_LEN - 1);
   localparam logic [7:0] SamplesW   = 8'(SAMPLES_PER_FRAME);

   logic signed [15:0] pred_ff, pred_in;
   logic [6:0]         step_ff, step_in;
   logic [6:0]         byte_counter_ff, byte_counter_in;
   logic [7:0]         sample_counter_ff, sample_counter_in;
   logic [7:0]         held_ff, held_in;
   logic               drop_rest_ff, drop_rest_in;

   logic               accept;
   logic               nearly_full;
   logic               drop;
   logic               bad_index;
   logic [6:0]         idx;
   logic [7:0]         sc;
   logic [1:0]         push_num, push_count;
   result_type         push0, push1, rsp_data;
   status_type         st;
   logic signed [15:0] p0, p1;
   logic [6:0]         i0, i1;

   assign req_stall = nearly_full;
   assign accept    = req_valid && !req_stall;

   imadec_nibble u_nib_lo (
      .pred_in   (pred_ff),
      .index_in  (step_ff),
      .code      (req_data_byte[3:0]),
      .pred_out  (p0),
      .index_out (i0)
   );

   imadec_nibble u_nib_hi (
      .pred_in   (p0),
      .index_in  (i0),
      .code      (req_data_byte[7:4]),
      .pred_out  (p1),
      .index_out (i1)
   );

   always_comb begin
      drop = req_first_byte ? 1'b0 : drop_rest_ff;
      idx  = req_first_byte ? 7'd0 : byte_counter_ff;
      sc   = req_first_byte ? 8'd0 : sample_counter_ff;
      pred_in           = pred_ff;
      step_in           = step_ff;
      byte_counter_in   = idx;
      sample_counter_in = sc;
      held_in           = held_ff;
      drop_rest_in      = drop;
      bad_index         = 1'b0;
      push_count        = 2'd0;
      push0             = '{sample: 16'sd0, end_of_frame: 1'b0, status: STATUS_OK};
      push1             = '{sample: 16'sd0, end_of_frame: 1'b0, status: STATUS_OK};
      st                = STATUS_BAD_LENGTH;
      if (!drop) begin
         byte_counter_in = (idx < 7'd127) ? idx + 7'd1 : 7'd127;
         if (idx == 7'd0) begin
            held_in = req_data_byte;
         end else if (idx == 7'd1) begin
            pred_in = $signed({req_data_byte, held_ff});
         end else if (idx == 7'd2) begin
            if (req_data_byte > {1'b0, MAX_INDEX}) begin
               push0        = '{sample: 16'sd0, end_of_frame: 1'b1, status: STATUS_BAD_INDEX};
               push_count   = 2'd1;
               drop_rest_in = 1'b1;
               bad_index    = 1'b1;
            end else begin
               step_in           = req_data_byte[6:0];
               push0.sample      = pred_ff;
               push_count        = 2'd1;
               sample_counter_in = 8'd1;
            end
         end else if (idx >= 7'd4 && {1'b0, idx} < PacketLenW && sc < SamplesW) begin
            push0.sample      = p0;
            push_count        = 2'd1;
            pred_in           = p0;
            step_in           = i0;
            sample_counter_in = sc + 8'd1;
            if (sc + 8'd1 < SamplesW) begin
               push1.sample      = p1;
               push_count        = 2'd2;
               pred_in           = p1;
               step_in           = i1;
               sample_counter_in = sc + 8'd2;
            end
         end
         // final byte tags the last result, or adds one of its own
         if (req_final_byte && !bad_index) begin
            if (idx == LastIdx && sample_counter_in == SamplesW) st = STATUS_OK;
            drop_rest_in = 1'b1;
            case (push_count)
               2'd0: begin
                  push0      = '{sample: 16'sd0, end_of_frame: 1'b1, status: st};
                  push_count = 2'd1;
               end
               2'd1: begin
                  push0.end_of_frame = 1'b1;
                  push0.status       = st;
               end
               default: begin
                  push1.end_of_frame = 1'b1;
                  push1.status       = st;
               end
            endcase
         end
      end
      push_num = accept ? push_count : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff           <= 16'sd0;
         step_ff           <= 7'd0;
         byte_counter_ff   <= 7'd0;
         sample_counter_ff <= 8'd0;
         held_ff           <= 8'd0;
         drop_rest_ff      <= 1'b0;
      end else if (accept) begin
         pred_ff           <= pred_in;
         step_ff           <= step_in;
         byte_counter_ff   <= byte_counter_in;
         sample_counter_ff <= sample_counter_in;
         held_ff           <= held_in;
         drop_rest_ff      <= drop_rest_in;
      end
   end

   imadec_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_num    (push_num),
      .push0       (push0),
      .push1       (push1),
      .nearly_full (nearly_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   assign rsp_sample       = rsp_data.sample;
   assign rsp_end_of_frame = rsp_data.end_of_frame;
   assign rsp_status       = rsp_data.status;

endmodule

@@ hw/rtl/imadec_nibble.sv @@
module imadec_nibble (
   input  logic signed [15:0] pred_in,
   input  logic [6:0]         index_in,
   input  logic [3:0]         code,
   output logic signed [15:0] pred_out,
   output logic [6:0]         index_out
);
   import imadec_pkg::*;

   logic [6:0]         idx_c;
   logic [14:0]        step;
   logic [16:0]        diff;
   logic signed [17:0] sum;
   logic signed [4:0]  adj;
   logic signed [7:0]  ni;

   always_comb begin
      idx_c = (index_in > MAX_INDEX) ? MAX_INDEX : index_in;
      step  = STEP_TABLE[idx_c];
      diff  = {5'd0, step[14:3]};
      if (code[2]) diff = diff + {2'd0, step};
      if (code[1]) diff = diff + {3'd0, step[14:1]};
      if (code[0]) diff = diff + {4'd0, step[14:2]};
      if (code[3]) begin
         sum = {{2{pred_in[15]}}, pred_in} - $signed({1'b0, diff});
      end else begin
         sum = {{2{pred_in[15]}}, pred_in} + $signed({1'b0, diff});
      end
      if (sum < -18'sd32768) begin
         pred_out = 16'sh8000;
      end else if (sum > 18'sd32767) begin
         pred_out = 16'sh7fff;
      end else begin
         pred_out = sum[15:0];
      end
      adj = INDEX_ADJUST[code[2:0]];
      ni  = $signed({1'b0, idx_c}) + {{3{adj[4]}}, adj};
      if (ni < 8'sd0) begin
         index_out = 7'd0;
      end else if (ni > $signed({1'b0, MAX_INDEX})) begin
         index_out = MAX_INDEX;
      end else begin
         index_out = ni[6:0];
      end
   end

endmodule

@@ hw/rtl/imadec_rsp_queue.sv @@
`include "ima_adpcm_frame_decoder_core_macros.svh"

module imadec_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_num,
   input  imadec_pkg::result_type push0,
   input  imadec_pkg::result_type push1,
   output logic                   nearly_full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output imadec_pkg::result_type rsp_data
);
   import imadec_pkg::*;

   localparam int Depth = 4;

   result_type entry_ff [Depth];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid   = (count_ff != 3'd0);
   assign rsp_data    = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   // room for two results must exist before a request is taken
   assign nearly_full = (count_ff > 3'(Depth - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_num;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_num} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) entry_ff[wr_ptr_ff] <= push0;
      if (push_num == 2'd2) entry_ff[wr_ptr_ff + 2'd1] <= push1;
   end

   `IMADEC_ASSERT(a_count_bound, count_ff <= 3'(Depth), "result queue overflow")
   `IMADEC_ASSERT(a_push_room, (push_num != 2'd0) |-> !nearly_full, "push while nearly full")
   `IMADEC_ASSERT(a_pop_only, (pop && push_num == 2'd0) |=> (count_ff == $past(count_ff) - 3'd1), "count did not drop on pop")
   `IMADEC_ASSERT(a_ptr_gap, (wr_ptr_ff - rd_ptr_ff) == count_ff[1:0], "pointer and count disagree")

endmodule
